// ===== rtl/core/tpw_pkg.sv =====
`timescale 1ns / 1ps

package tpw_pkg;

  // Result kinds, carried on the result channel's tuser.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WBACK = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_FAULT = 2'd3;

  // Input actions, carried on the input channel's tuser.
  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_RESPONSE  = 1'b1;

  // Fault kinds.
  localparam logic FAULT_NOT_PRESENT = 1'b0;
  localparam logic FAULT_PROTECTION  = 1'b1;

  // Walk phase codes; the unused code behaves as idle.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIR  = 2'd1;
  localparam logic [1:0] PH_TAB  = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PAGING_ENABLE = 2'd0;
  localparam logic [1:0] REG_DIR_BASE      = 2'd1;
  localparam logic [1:0] REG_ADDR_MASK     = 2'd2;

  // Accessed bit, and accessed plus dirty bits, of a table entry.
  localparam logic [31:0] ENTRY_ACCESSED       = 32'h0000_0020;
  localparam logic [31:0] ENTRY_ACCESSED_DIRTY = 32'h0000_0060;

  // Default depth of the result queue.
  localparam int TPW_RES_DEPTH = 4;

  typedef struct packed {
    logic        action;
    logic [31:0] lin_addr;
    logic        is_user;
    logic        is_write;
    logic [31:0] read_data;
  } tpw_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        large_page;
    logic        cache_disable;
    logic        write_through;
    logic        fault_kind;
    logic        fault_user;
    logic        fault_write;
    logic        last;
  } tpw_res_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] saved_linear;
    logic        saved_user;
    logic        saved_write;
    logic [31:0] entry_address;
  } tpw_state_t;

  typedef struct packed {
    logic        paging_enable;
    logic [19:0] dir_base;
    logic [31:0] addr_mask;
  } tpw_cfg_t;

endpackage

// ===== rtl/core/tpw_cfg.sv =====
`timescale 1ns / 1ps

module tpw_cfg
  import tpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output tpw_cfg_t    cfg
);

  tpw_cfg_t   cfg_r;
  tpw_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register write decode; addresses beyond the register list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PAGING_ENABLE: cfg_nxt.paging_enable = pwdata[0];
        REG_DIR_BASE:      cfg_nxt.dir_base      = pwdata[19:0];
        REG_ADDR_MASK:     cfg_nxt.addr_mask     = pwdata;
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paging_enable <= 1'b0;
      cfg_r.dir_base      <= 20'd0;
      cfg_r.addr_mask     <= 32'hFFFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_PAGING_ENABLE: prdata = {31'd0, cfg_r.paging_enable};
      REG_DIR_BASE:      prdata = {12'd0, cfg_r.dir_base};
      REG_ADDR_MASK:     prdata = cfg_r.addr_mask;
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/tpw_step.sv =====
`timescale 1ns / 1ps

module tpw_step
  import tpw_pkg::*;
(
  input  tpw_item_t  item,
  input  tpw_state_t st,
  input  tpw_cfg_t   cfg,
  output tpw_res_t   res0,
  output tpw_res_t   res1,
  output logic [1:0] num_res,
  output tpw_state_t st_nxt
);

  logic [31:0] e;
  logic        not_present;
  logic        prot_fail;
  logic        walking;

  assign e           = item.read_data;
  assign not_present = !e[0];
  assign prot_fail   = st.saved_user && (!e[2] || (st.saved_write && !e[1]));
  assign walking     = (st.phase == PH_DIR) || (st.phase == PH_TAB);

  // One walk step. Entry addresses are plain concatenations because the
  // index offsets never carry past the page-aligned base.
  always_comb begin
    st_nxt  = st;
    res0    = '0;
    res1    = '0;
    num_res = 2'd0;
    if (item.action == ACT_TRANSLATE) begin
      st_nxt.saved_linear = item.lin_addr;
      st_nxt.saved_user   = item.is_user;
      st_nxt.saved_write  = item.is_write;
      num_res             = 2'd1;
      res0.last           = 1'b1;
      if (!cfg.paging_enable) begin
        // Identity mapping, uncached and never masked.
        st_nxt.phase       = PH_IDLE;
        res0.kind          = KIND_DONE;
        res0.address       = item.lin_addr;
        res0.cache_disable = 1'b1;
        res0.write_through = 1'b1;
      end else begin
        st_nxt.entry_address = {cfg.dir_base, item.lin_addr[31:22], 2'b00};
        st_nxt.phase         = PH_DIR;
        res0.kind            = KIND_READ;
        res0.address         = {cfg.dir_base, item.lin_addr[31:22], 2'b00};
      end
    end else if (walking) begin
      if (not_present || prot_fail) begin
        // Failing entry: report the fault, no write-back.
        st_nxt.phase     = PH_IDLE;
        num_res          = 2'd1;
        res0.kind        = KIND_FAULT;
        res0.address     = st.saved_linear;
        res0.fault_kind  = not_present ? FAULT_NOT_PRESENT : FAULT_PROTECTION;
        res0.fault_user  = st.saved_user;
        res0.fault_write = st.saved_write;
        res0.last        = 1'b1;
      end else begin
        num_res         = 2'd2;
        res0.kind       = KIND_WBACK;
        res0.address    = st.entry_address;
        res0.write_data = e | (st.saved_write ? ENTRY_ACCESSED_DIRTY : ENTRY_ACCESSED);
        res1.last       = 1'b1;
        if (st.phase == PH_DIR && e[7]) begin
          // Large page ends the walk at the directory.
          st_nxt.phase       = PH_IDLE;
          res1.kind          = KIND_DONE;
          res1.address       = {e[31:22], st.saved_linear[21:0]} & cfg.addr_mask;
          res1.large_page    = 1'b1;
          res1.cache_disable = e[4];
          res1.write_through = e[3];
        end else if (st.phase == PH_DIR) begin
          st_nxt.entry_address = {e[31:12], st.saved_linear[21:12], 2'b00};
          st_nxt.phase         = PH_TAB;
          res1.kind            = KIND_READ;
          res1.address         = {e[31:12], st.saved_linear[21:12], 2'b00};
        end else begin
          st_nxt.phase       = PH_IDLE;
          res1.kind          = KIND_DONE;
          res1.address       = {e[31:12], st.saved_linear[11:0]} & cfg.addr_mask;
          res1.cache_disable = e[4];
          res1.write_through = e[3];
        end
      end
    end
  end

endmodule

// ===== rtl/core/tpw_resq.sv =====
`timescale 1ns / 1ps

module tpw_resq
  import tpw_pkg::*;
#(
  parameter int Depth = TPW_RES_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_num,
  input  tpw_res_t   push0,
  input  tpw_res_t   push1,
  output logic       room_two,
  output logic       pop_valid,
  input  logic       pop_ready,
  output tpw_res_t   pop_word
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tpw_res_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room_two  = (cnt_r <= CntW'(Depth - 2));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_word  = mem[rd_ptr_r];
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_num == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push_num == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CntW'(push_num) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage; up to two words are written per cycle.
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  // The queue never holds more words than it has entries.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("result queue overflow");

  // Two words are only pushed when there was room for both.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_num == 2'd2) |-> room_two)
    else $error("double push without room");

endmodule

// ===== rtl/core/two_level_page_walker.sv =====
`timescale 1ns / 1ps

// Two-level 32-bit page walker. Each input word is either a translate request
// (tuser 0) or a memory read response carrying a table entry (tuser 1). It is
// held in the input register, where the walk step is evaluated, and its
// one or two result words (read request, entry write-back, done, or page
// fault; tlast marks the final one) go into a small result queue that feeds
// the output. One input word is taken per cycle as long as the queue has room
// for two more results; a response that passes its checks yields two result
// words, so a stream of such responses is paced by the output at one word per
// cycle while out_tready stays high. A word's results are written into the
// result queue as it leaves the input register, and the queue head drives the
// output. A response that arrives while no walk is pending is dropped
// silently, and a translate request abandons any pending walk. Configuration
// may only be written while the walker is idle.
module two_level_page_walker
  import tpw_pkg::*;
#(
  parameter int ResDepth = TPW_RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: lin_addr[31:0], is_user[32], is_write[33], read_data[65:34]
  input  logic [71:0] in_tdata,
  // tuser: action[0]
  input  logic [0:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: address[31:0], write_data[63:32], large_page[64],
  // cache_disable[65], write_through[66], fault_kind[67], fault_user[68],
  // fault_write[69]
  output logic [71:0] out_tdata,
  // tuser: kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tpw_cfg_t   cfg;
  tpw_item_t  item_r;
  logic       item_valid_r;
  tpw_state_t st_r, st_nxt, st_step;
  tpw_res_t   res0, res1, out_word;
  logic [1:0] step_num;
  logic [1:0] push_num;
  logic       room_two;
  logic       advance;

  tpw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input register stage.
  assign advance   = item_valid_r && room_two;
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action    <= in_tuser[0];
      item_r.lin_addr  <= in_tdata[31:0];
      item_r.is_user   <= in_tdata[32];
      item_r.is_write  <= in_tdata[33];
      item_r.read_data <= in_tdata[65:34];
    end
  end

  // Walk step on the registered word.
  tpw_step u_step (
    .item    (item_r),
    .st      (st_r),
    .cfg     (cfg),
    .res0    (res0),
    .res1    (res1),
    .num_res (step_num),
    .st_nxt  (st_step)
  );

  assign push_num = advance ? step_num : 2'd0;
  assign st_nxt   = advance ? st_step : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  tpw_resq #(
    .Depth (ResDepth)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push0     (res0),
    .push1     (res1),
    .room_two  (room_two),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_word  (out_word)
  );

  // Output packing.
  assign out_tdata = {2'b00, out_word.fault_write, out_word.fault_user,
                      out_word.fault_kind, out_word.write_through,
                      out_word.cache_disable, out_word.large_page,
                      out_word.write_data, out_word.address};
  assign out_tuser = out_word.kind;
  assign out_tlast = out_word.last;

  // A fault always closes the results of its input word.
  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_FAULT) |-> out_tlast)
    else $error("fault word without tlast");

  // A write-back is always followed by another result of the same word.
  a_wback_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_WBACK) |-> !out_tlast)
    else $error("write-back word marked last");

  // A translate request with paging off leaves the walker idle.
  a_identity_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.action == ACT_TRANSLATE && !cfg.paging_enable)
      |=> (st_r.phase == PH_IDLE))
    else $error("walk pending after identity translation");

  // A step that is taken always pushes at least one result, except a dropped response.
  a_push_on_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (item_r.action == ACT_TRANSLATE || st_r.phase == PH_DIR ||
                 st_r.phase == PH_TAB)) |-> (push_num != 2'd0))
    else $error("step produced no result");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tpw_pkg::*;

  // Walk predictor and queue of results still owed by the walker.
  class walk_scoreboard;
    logic        paging_on;
    logic [19:0] dir_frame;
    logic [31:0] phys_mask;
    logic [1:0]  phase;
    logic [31:0] la_saved;
    logic        user_saved;
    logic        write_saved;
    logic [31:0] entry_addr;
    tpw_res_t    owed_q[$];
    int          mismatches;
    int          checked;
    int          faults;
    int          walks_done;
    int          large_done;

    function new();
      paging_on   = 1'b0;
      dir_frame   = '0;
      phys_mask   = 32'hFFFF_FFFF;
      phase       = PH_IDLE;
      la_saved    = '0;
      user_saved  = 1'b0;
      write_saved = 1'b0;
      entry_addr  = '0;
      mismatches  = 0;
      checked     = 0;
      faults      = 0;
      walks_done  = 0;
      large_done  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_PAGING_ENABLE: paging_on = value[0];
        REG_DIR_BASE:      dir_frame = value[19:0];
        REG_ADDR_MASK:     phys_mask = value;
        default: ;
      endcase
    endfunction

    // Queue one owed result; fault attributes are only carried on faults.
    function void owe(logic [1:0] kind, logic [31:0] addr, logic [31:0] wdata,
                      logic lp, logic cd, logic wt, logic fk, logic last);
      tpw_res_t r;
      r.kind          = kind;
      r.address       = addr;
      r.write_data    = wdata;
      r.large_page    = lp;
      r.cache_disable = cd;
      r.write_through = wt;
      r.fault_kind    = (kind == KIND_FAULT) ? fk : 1'b0;
      r.fault_user    = (kind == KIND_FAULT) ? user_saved : 1'b0;
      r.fault_write   = (kind == KIND_FAULT) ? write_saved : 1'b0;
      r.last          = last;
      owed_q.push_back(r);
    endfunction

    // Advance the walk by one accepted word; returns the number of results.
    function int note_item(tpw_item_t it);
      logic [31:0] e;
      logic [31:0] pa;
      logic        absent;
      logic        denied;
      e = it.read_data;
      if (it.action == ACT_TRANSLATE) begin
        la_saved    = it.lin_addr;
        user_saved  = it.is_user;
        write_saved = it.is_write;
        if (!paging_on) begin
          phase = PH_IDLE;
          owe(KIND_DONE, it.lin_addr, '0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
          return 1;
        end
        entry_addr = {dir_frame, 12'h000} + {20'h0, it.lin_addr[31:22], 2'b00};
        phase = PH_DIR;
        owe(KIND_READ, entry_addr, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        return 1;
      end
      // A response with no walk pending is dropped.
      if (phase != PH_DIR && phase != PH_TAB) return 0;
      absent = !e[0];
      denied = !absent && user_saved && (!e[2] || (write_saved && !e[1]));
      if (absent || denied) begin
        phase = PH_IDLE;
        owe(KIND_FAULT, la_saved, '0, 1'b0, 1'b0, 1'b0,
            denied ? FAULT_PROTECTION : FAULT_NOT_PRESENT, 1'b1);
        return 1;
      end
      owe(KIND_WBACK, entry_addr,
          e | (write_saved ? ENTRY_ACCESSED_DIRTY : ENTRY_ACCESSED),
          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      if (phase == PH_DIR && !e[7]) begin
        entry_addr = {e[31:12], 12'h000} + {20'h0, la_saved[21:12], 2'b00};
        phase = PH_TAB;
        owe(KIND_READ, entry_addr, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        return 2;
      end
      // Either a large page at the directory or a small page at the table.
      if (phase == PH_DIR) pa = {e[31:22], la_saved[21:0]};
      else pa = {e[31:12], la_saved[11:0]};
      owe(KIND_DONE, pa & phys_mask, '0, phase == PH_DIR, e[4], e[3], 1'b0, 1'b1);
      phase = PH_IDLE;
      return 2;
    endfunction

    function void check_result(tpw_res_t got);
      tpw_res_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result kind %0d address %h", got.kind, got.address);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.kind == KIND_FAULT) faults++;
      if (got.kind == KIND_DONE) walks_done++;
      if (got.kind == KIND_DONE && got.large_page) large_done++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: mismatch (want/got) kind %0d/%0d addr %h/%h wdata %h/%h",
                   want.kind, got.kind, want.address, got.address,
                   want.write_data, got.write_data);
          $display("tb:   lp %b/%b cd %b/%b wt %b/%b fk %b/%b fu %b/%b fw %b/%b last %b/%b",
                   want.large_page, got.large_page,
                   want.cache_disable, got.cache_disable,
                   want.write_through, got.write_through,
                   want.fault_kind, got.fault_kind, want.fault_user, got.fault_user,
                   want.fault_write, got.fault_write, want.last, got.last);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  walk_scoreboard sb = new();
  bit calm = 1'b0;
  int words_sent = 0;
  int words_dropped = 0;
  int counted = 0;

  two_level_page_walker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 31);
  end

  // Check every result word taken from the walker.
  always @(posedge clk) begin
    tpw_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind          = out_tuser;
      got.address       = out_tdata[31:0];
      got.write_data    = out_tdata[63:32];
      got.large_page    = out_tdata[64];
      got.cache_disable = out_tdata[65];
      got.write_through = out_tdata[66];
      got.fault_kind    = out_tdata[67];
      got.fault_user    = out_tdata[68];
      got.fault_write   = out_tdata[69];
      got.last          = out_tlast;
      sb.check_result(got);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Send one word, leaving valid high after it is taken.
  task automatic send_word(input tpw_item_t it);
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {6'b0, it.read_data, it.is_write, it.is_user, it.lin_addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (sb.note_item(it) > 0) counted++;
    else words_dropped++;
  endtask

  task automatic translate(input logic [31:0] la, input logic user, input logic wr);
    tpw_item_t it;
    it.action    = ACT_TRANSLATE;
    it.lin_addr  = la;
    it.is_user   = user;
    it.is_write  = wr;
    it.read_data = $urandom;
    send_word(it);
  endtask

  task automatic respond(input logic [31:0] entry);
    tpw_item_t it;
    it.action    = ACT_RESPONSE;
    it.lin_addr  = $urandom;
    it.is_user   = 1'($urandom_range(1));
    it.is_write  = 1'($urandom_range(1));
    it.read_data = entry;
    send_word(it);
  endtask

  // Drain all owed results, then give the walker time to finish dropped words.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic pg, input logic [19:0] dir, input logic [31:0] mask);
    settle();
    write_reg(REG_PAGING_ENABLE, {31'b0, pg});
    write_reg(REG_DIR_BASE, {12'b0, dir});
    write_reg(REG_ADDR_MASK, mask);
  endtask

  // Random entry word, mostly present and permissive so walks go deep.
  function automatic logic [31:0] rand_entry(bit at_dir);
    logic [31:0] e;
    e = $urandom;
    e[0] = ($urandom_range(99) < 88);
    e[2] = ($urandom_range(99) < 80);
    e[1] = ($urandom_range(99) < 75);
    if (at_dir) e[7] = ($urandom_range(99) < 40);
    return e;
  endfunction

  // Mostly complete walks, plus stray responses and abandoned walks.
  task automatic random_traffic(input int n);
    int stop;
    int pick;
    stop = counted + n;
    while (counted < stop) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        translate($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if (sb.phase == PH_DIR) respond(rand_entry(1'b1));
        if (sb.phase == PH_TAB && $urandom_range(99) < 95) respond(rand_entry(1'b0));
      end else if (pick < 90) begin
        respond($urandom);
      end else begin
        translate($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(1)) respond(rand_entry(1'b1));
      end
    end
  endtask

  initial begin
    int failures;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity mapping after reset, and a response with no walk pending.
    translate(32'h0000_0000, 1'b0, 1'b0);
    translate(32'hFFFF_FFFF, 1'b1, 1'b1);
    respond(32'hFFFF_FFFF);

    configure(1'b1, 20'hFFFFF, 32'hFFFF_FFFF);
    // Large page with every entry bit set, user write.
    translate(32'hFFFF_FFFF, 1'b1, 1'b1);
    respond(32'hFFFF_FFFF);
    // Directory entry not present.
    translate(32'h0000_0000, 1'b0, 1'b0);
    respond(32'h0000_0000);
    // User write to a read-only user entry.
    translate(32'h0040_0000, 1'b1, 1'b1);
    respond(32'h0000_0005);
    // User read through a read-only directory entry to a small page.
    translate(32'h1234_5678, 1'b1, 1'b0);
    respond(32'h0000_0005);
    respond(32'hABCD_E007);
    // Supervisor write ignores the user and writable bits; cache-disable and write-through bits set.
    translate(32'h89AB_CDEF, 1'b0, 1'b1);
    respond(32'h0000_0001);
    respond(32'h0000_0019);
    // Table entry faults: protection, then not present.
    translate(32'h7654_3210, 1'b1, 1'b1);
    respond(32'hFFFF_F007);
    respond(32'h0000_0005);
    translate(32'h0000_1000, 1'b0, 1'b0);
    respond(32'h0000_0007);
    respond(32'hFFFF_FFFE);
    // A new request abandons a walk waiting on its table entry.
    translate(32'hDEAD_BEEF, 1'b0, 1'b0);
    respond(32'h0000_1007);
    translate(32'hCAFE_F00D, 1'b1, 1'b0);
    respond(32'h0001_2007);
    respond(32'h0003_4007);

    // Mask gates address bit 20 on a large page; directory at frame zero.
    configure(1'b1, 20'h00000, 32'hFFEF_FFFF);
    translate(32'hFFFF_FFFF, 1'b0, 1'b0);
    respond(32'hFFC0_0081);

    configure(1'b1, 20'h00000, 32'hFFFF_FFFF);
    random_traffic(320);
    configure(1'b1, 20'hFFFFF, 32'h0000_0000);
    random_traffic(320);
    configure(1'b0, 20'($urandom), $urandom);
    random_traffic(200);
    configure(1'b1, 20'($urandom), 32'hFFEF_FFFF);
    calm = 1'b1;
    random_traffic(320);
    calm = 1'b0;
    configure(1'b1, 20'($urandom), $urandom);
    random_traffic(320);

    settle();
    repeat (10) @(posedge clk);
    failures = sb.mismatches + sb.pending();
    if (sb.pending() != 0)
      $display("tb: %0d expected results never arrived", sb.pending());
    $display("tb: %0d words sent, %0d dropped responses, %0d results checked",
             words_sent, words_dropped, sb.checked);
    $display("tb: %0d walks completed (%0d large pages), %0d page faults, %0d errors",
             sb.walks_done, sb.large_done, sb.faults, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
